// File: design/rotor_cipher_wheel_macros.svh
// Assertion helpers used by the rotor cipher wheel top-level design file.
`ifndef ROTOR_CIPHER_WHEEL_MACROS_SVH
`define ROTOR_CIPHER_WHEEL_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define RCW_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rotor_cipher_wheel: assertion failed");

// Checks that a consequence holds in the cycle after its trigger.
`define RCW_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("rotor_cipher_wheel: assertion failed");

`else

`define RCW_ASSERT_ALWAYS(label, clk, rst, cond)
`define RCW_ASSERT_NEXT(label, clk, rst, trig, cons)

`endif

`endif

// File: design/rcw_pkg.sv
package rcw_pkg;

  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 6;
  localparam int LETTERS  = 26;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // One bit wider than a letter so that a sum of two letters fits.
  localparam logic [LETTER_W:0] NUM_LETTERS = 6'd26;

  localparam count_t MID_PERIOD  = 6'd26;
  localparam count_t SLOW_PERIOD = 6'd52;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_START_POSITION = 2'd0;
  localparam logic [1:0] REG_ROTOR_ROLE     = 2'd1;
  localparam logic [1:0] REG_WIRING_SELECT  = 2'd2;

  // Stepping roles.
  localparam logic [1:0] ROLE_EVERY = 2'd0;
  localparam logic [1:0] ROLE_MID   = 2'd1;
  localparam logic [1:0] ROLE_SLOW  = 2'd2;
  localparam logic [1:0] ROLE_HOLD  = 2'd3;

  localparam letter_t SCRAMBLED [LETTERS] = '{
    5'd22, 5'd17, 5'd24, 5'd8,  5'd15, 5'd10, 5'd7,  5'd5,  5'd18, 5'd25,
    5'd2,  5'd1,  5'd12, 5'd16, 5'd13, 5'd4,  5'd21, 5'd19, 5'd23, 5'd20,
    5'd0,  5'd14, 5'd3,  5'd11, 5'd6,  5'd9
  };

  localparam letter_t SCRAMBLED_INV [LETTERS] = '{
    5'd20, 5'd11, 5'd10, 5'd22, 5'd15, 5'd7,  5'd24, 5'd6,  5'd3,  5'd25,
    5'd5,  5'd23, 5'd12, 5'd14, 5'd21, 5'd4,  5'd13, 5'd1,  5'd8,  5'd17,
    5'd19, 5'd16, 5'd0,  5'd18, 5'd2,  5'd9
  };

  // After reset the letter a sits at slot 0 of the scrambled wiring.
  localparam letter_t RESET_OFFSET = SCRAMBLED_INV[0];

  typedef struct packed {
    logic            we;
    logic [1:0]      index;
    logic [LETTER_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    letter_t letter;
    logic    was_return;
  } result_t;

  typedef struct packed {
    letter_t offset;
    logic    pending;
    count_t  counter;
  } rotor_status_t;

endpackage

// File: design/rcw_in_stage.sv
module rcw_in_stage
  import rcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  letter_t letter_in,
  input  logic    advance,
  output logic    held_valid,
  output letter_t held_letter
);

  logic    valid;
  letter_t letter;

  // The register frees up in the same cycle that its letter moves on.
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      letter <= letter_in;
    end
  end

  assign held_valid  = valid;
  assign held_letter = letter;

endmodule

// File: design/rcw_rotor.sv
module rcw_rotor
  import rcw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_write_t    cfg,
  input  logic          advance,
  input  letter_t       letter,
  output result_t       result,
  output rotor_status_t status
);

  letter_t    start_position;
  logic [1:0] rotor_role;
  logic       wiring_select;
  letter_t    offset;
  logic       pending;
  count_t     counter;

  letter_t ch;
  logic    step;
  count_t  counter_fwd;
  letter_t offset_fwd;
  letter_t fwd_idx;
  letter_t fwd_res;
  letter_t inv_val;
  letter_t inv_res;
  letter_t seat_sp;
  logic    seat_ws;
  letter_t seat_key;
  letter_t seat_slot;
  letter_t seat_offset;

  // Folds a value below 52 into 0..25.
  function automatic letter_t reduce(logic [LETTER_W:0] s);
    logic [LETTER_W:0] r;
    r = (s >= NUM_LETTERS) ? s - NUM_LETTERS : s;
    return r[LETTER_W-1:0];
  endfunction

  function automatic letter_t add_mod(letter_t a, letter_t b);
    return reduce({1'b0, a} + {1'b0, b});
  endfunction

  function automatic letter_t sub_mod(letter_t a, letter_t b);
    return reduce({1'b0, a} + NUM_LETTERS - {1'b0, b});
  endfunction

  assign ch = reduce({1'b0, letter});

  always_comb begin
    step        = 1'b0;
    counter_fwd = counter;
    unique case (rotor_role)
      ROLE_EVERY: begin
        step = 1'b1;
      end
      ROLE_MID: begin
        step        = (counter >= MID_PERIOD);
        counter_fwd = (step ? '0 : counter) + count_t'(1);
      end
      ROLE_SLOW: begin
        step        = (counter >= SLOW_PERIOD);
        counter_fwd = (step ? '0 : counter) + count_t'(1);
      end
      ROLE_HOLD: begin
        step = 1'b0;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  assign offset_fwd = step ? add_mod(offset, letter_t'(1)) : offset;

  assign fwd_idx = add_mod(ch, offset_fwd);
  assign fwd_res = wiring_select ? fwd_idx : SCRAMBLED[fwd_idx];
  assign inv_val = wiring_select ? ch : SCRAMBLED_INV[ch];
  assign inv_res = sub_mod(inv_val, offset);

  assign result.letter     = pending ? inv_res : fwd_res;
  assign result.was_return = pending;

  // Seating uses the value being written so that a sits at the new slot.
  assign seat_sp     = (cfg.index == REG_START_POSITION) ? cfg.data : start_position;
  assign seat_ws     = (cfg.index == REG_WIRING_SELECT) ? cfg.data[0] : wiring_select;
  assign seat_key    = reduce({1'b0, seat_sp});
  assign seat_slot   = seat_ws ? '0 : SCRAMBLED_INV[0];
  assign seat_offset = sub_mod(seat_slot, seat_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      rotor_role     <= ROLE_EVERY;
      wiring_select  <= 1'b0;
      offset         <= RESET_OFFSET;
      pending        <= 1'b0;
      counter        <= '0;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_START_POSITION: begin
          start_position <= cfg.data;
          offset         <= seat_offset;
          pending        <= 1'b0;
          counter        <= '0;
        end
        REG_ROTOR_ROLE: begin
          rotor_role <= cfg.data[1:0];
        end
        REG_WIRING_SELECT: begin
          wiring_select <= cfg.data[0];
          offset        <= seat_offset;
          pending       <= 1'b0;
          counter       <= '0;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      pending <= !pending;
      if (!pending) begin
        offset  <= offset_fwd;
        counter <= counter_fwd;
      end
    end
  end

  assign status.offset  = offset;
  assign status.pending = pending;
  assign status.counter = counter;

endmodule

// File: design/rcw_out_stage.sv
module rcw_out_stage
  import rcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  result_t result,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t held
);

  logic    valid;
  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data <= result;
    end
  end

  assign m_tvalid = valid;
  assign held     = data;

endmodule

// File: design/rotor_cipher_wheel.sv
// One rotor of a rotor cipher: each request carries one letter (0 = a .. 25 = z)
// and returns one substituted letter. Requests alternate between a forward
// pass, which may step the rotor first by its role, and a return pass through
// the inverse wiring; m_tuser marks the return pass. The add, table lookup and
// step update are combinational between an input register and a result
// register, so a letter accepted into the input register reaches m_tdata from
// the result register. With m_tready held high the block takes one letter every
// clock cycle; while a result waits on a low m_tready the input register fills
// and s_tready drops until the result is taken. Configuration writes must be
// made by the user only while no request is in flight; the block itself does
// not enforce this. Writing the start position or the wiring select re-seats
// the rotor and restarts the pass sequence with a forward pass.
`include "rotor_cipher_wheel_macros.svh"

module rotor_cipher_wheel
  import rcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] letter_in, [7:5] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] letter_out, [7:5] zero
  output logic       m_tuser,   // [0] was_return_pass
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  logic          held_valid;
  letter_t       held_letter;
  logic          advance;
  cfg_write_t    cfg;
  result_t       result;
  result_t       out_item;
  rotor_status_t status;
  logic          pass_flag;

  assign advance = held_valid && (!m_tvalid || m_tready);

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rcw_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .letter_in   (s_tdata[4:0]),
    .advance     (advance),
    .held_valid  (held_valid),
    .held_letter (held_letter)
  );

  rcw_rotor u_rotor (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .letter  (held_letter),
    .result  (result),
    .status  (status)
  );

  rcw_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (out_item)
  );

  assign m_tdata = {3'b000, out_item.letter};
  assign m_tuser = out_item.was_return;

  assign pass_flag = status.pending;

  `RCW_ASSERT_ALWAYS(a_offset_range, clk, rst, {1'b0, status.offset} < NUM_LETTERS)
  `RCW_ASSERT_ALWAYS(a_counter_range, clk, rst, status.counter <= SLOW_PERIOD)
  `RCW_ASSERT_NEXT(a_pass_alternates, clk, rst, advance && !cfg_we, pass_flag != $past(pass_flag))
  `RCW_ASSERT_NEXT(a_pass_flag_out, clk, rst, advance, m_tvalid && (m_tuser == $past(pass_flag)))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcw_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_TAIL = 120;
  // Index 3 is not a register; a write there must leave the rotor alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_LETTER, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] index;
    logic [4:0] value;
    bit         typed;
    result_t    typed_res;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [4:0] cfg_data = 5'd0;

  // Rotor state and register copies for the letter predictor.
  letter_t    wheel_offset;
  logic       wheel_pending;
  count_t     wheel_count;
  logic [4:0] cur_start;
  logic [1:0] cur_role;
  logic       cur_wiring;

  result_t    expected_out[$];
  plan_row_t  plan[$];
  int         errors = 0;
  int         idle_pct = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  rotor_cipher_wheel dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void reseat_wheel();
    int a_slot;
    a_slot = cur_wiring ? 0 : int'(SCRAMBLED_INV[0]);
    wheel_offset = letter_t'((a_slot + LETTERS - cur_start % LETTERS) % LETTERS);
    wheel_pending = 1'b0;
    wheel_count = '0;
  endfunction

  function automatic result_t predict_letter(input logic [4:0] raw);
    int ch;
    int period;
    int slot;
    result_t r;
    ch = (raw >= LETTERS) ? int'(raw) - LETTERS : int'(raw);
    r.was_return = wheel_pending;
    if (!wheel_pending) begin
      if (cur_role == ROLE_EVERY) begin
        wheel_offset = letter_t'((wheel_offset + 1) % LETTERS);
      end else if (cur_role == ROLE_MID || cur_role == ROLE_SLOW) begin
        period = (cur_role == ROLE_MID) ? int'(MID_PERIOD) : int'(SLOW_PERIOD);
        if (wheel_count >= period) begin
          wheel_offset = letter_t'((wheel_offset + 1) % LETTERS);
          wheel_count = '0;
        end
        wheel_count = wheel_count + 1'b1;
      end
      slot = (ch + wheel_offset) % LETTERS;
      r.letter = cur_wiring ? letter_t'(slot) : SCRAMBLED[slot];
      wheel_pending = 1'b1;
    end else begin
      slot = cur_wiring ? ch : int'(SCRAMBLED_INV[ch]);
      r.letter = letter_t'((slot + LETTERS - wheel_offset) % LETTERS);
      wheel_pending = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_letter(input logic [4:0] raw, input bit typed,
                                     input letter_t want_letter, input logic want_ret);
    plan_row_t row;
    row.kind = ROW_LETTER;
    row.index = '0;
    row.value = raw;
    row.typed = typed;
    row.typed_res.letter = want_letter;
    row.typed_res.was_return = want_ret;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input logic [1:0] index, input logic [4:0] value);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.index = index;
    row.value = value;
    row.typed = 1'b0;
    row.typed_res = '0;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Drops the request line and waits until every expected result is back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [4:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_START_POSITION: begin
        cur_start = value;
        reseat_wheel();
      end
      REG_ROTOR_ROLE: cur_role = value[1:0];
      REG_WIRING_SELECT: begin
        cur_wiring = value[0];
        reseat_wheel();
      end
      default: ;
    endcase
  endtask

  task automatic send_letter(input logic [4:0] raw, input bit typed,
                             input result_t typed_res);
    result_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, raw};
    do @(posedge clk); while (!s_tready);
    predicted = predict_letter(raw);
    expected_out.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("result with no request waiting, letter", m_tdata[4:0], -1);
      end else begin
        want = expected_out.pop_front();
        if (m_tdata[4:0] != want.letter)
          report_mismatch("letter_out", m_tdata[4:0], want.letter);
        if (m_tuser != want.was_return)
          report_mismatch("was_return_pass", m_tuser, want.was_return);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n_items;
    int phase;
    int plen;
    logic [4:0] raw;
    result_t none;

    none = '0;
    cur_start = '0;
    cur_role = ROLE_EVERY;
    cur_wiring = 1'b0;
    reseat_wheel();

    // Out of reset the wheel sits at offset 20 and steps on every forward pass.
    add_letter(5'd0, 1'b1, 5'd14, 1'b0);
    add_letter(5'd14, 1'b1, 5'd0, 1'b1);
    add_letter(5'd25, 1'b0, '0, 1'b0);
    add_letter(5'd31, 1'b0, '0, 1'b0);
    add_letter(5'd26, 1'b0, '0, 1'b0);
    add_letter(5'd25, 1'b0, '0, 1'b0);
    // Identity wiring makes the offset directly visible.
    add_write(REG_WIRING_SELECT, 5'd1);
    add_letter(5'd0, 1'b1, 5'd1, 1'b0);
    add_letter(5'd1, 1'b1, 5'd0, 1'b1);
    add_letter(5'd25, 1'b1, 5'd1, 1'b0);
    add_letter(5'd30, 1'b1, 5'd2, 1'b1);
    // A start position of 31 is taken as 5.
    add_write(REG_START_POSITION, 5'd31);
    add_letter(5'd0, 1'b1, 5'd22, 1'b0);
    add_letter(5'd0, 1'b1, 5'd4, 1'b1);
    add_write(REG_ROTOR_ROLE, 5'(ROLE_HOLD));
    add_letter(5'd3, 1'b1, 5'd25, 1'b0);
    add_letter(5'd25, 1'b1, 5'd3, 1'b1);
    add_write(REG_ROTOR_ROLE, 5'(ROLE_MID));
    add_write(REG_UNUSED, 5'd31);
    add_letter(5'd7, 1'b1, 5'd3, 1'b0);
    add_letter(5'd3, 1'b1, 5'd7, 1'b1);
    add_write(REG_WIRING_SELECT, 5'd0);
    add_letter(5'd12, 1'b0, '0, 1'b0);
    add_letter(5'd12, 1'b0, '0, 1'b0);
    add_write(REG_ROTOR_ROLE, 5'(ROLE_SLOW));
    add_write(REG_START_POSITION, 5'd25);
    add_letter(5'd0, 1'b0, '0, 1'b0);
    add_letter(5'd31, 1'b0, '0, 1'b0);
    add_write(REG_START_POSITION, 5'd0);
    add_write(REG_ROTOR_ROLE, 5'(ROLE_EVERY));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        write_reg(plan[i].index, plan[i].value);
      else
        send_letter(plan[i].value, plan[i].typed, plan[i].typed_res);
    end

    n_items = 0;
    phase = 0;
    while (n_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (n_items >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
      write_reg(REG_ROTOR_ROLE, 5'($urandom_range(0, 3)));
      write_reg(REG_START_POSITION, 5'($urandom_range(0, 31)));
      write_reg(REG_WIRING_SELECT, 5'($urandom_range(0, 31)));
      // Long phases let the slow role reach its first step.
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(110, 170) : $urandom_range(16, 70);
      if (plen > RANDOM_ITEMS - n_items) plen = RANDOM_ITEMS - n_items;
      for (int k = 0; k < plen; k++) begin
        if (n_items + k >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
        raw = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                          : 5'($urandom_range(0, 25));
        send_letter(raw, 1'b0, none);
        if (phase == 1 && k == plen / 2) wait_for_results();
      end
      n_items += plen;
      phase++;
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: rotor_cipher_wheel.f
+incdir+design
design/rcw_pkg.sv
design/rcw_in_stage.sv
design/rcw_rotor.sv
design/rcw_out_stage.sv
design/rotor_cipher_wheel.sv
verif/testbench.sv
